FILE: rtl/sfct_pkg.sv
`timescale 1ns / 1ps

package sfct_pkg;

  // Fixed-point formats of the fields.
  localparam int FRAC    = 16;
  localparam int POS_W   = 20;
  localparam int VEL_W   = 24;
  localparam int PHASE_W = 16;

  // Quarter-wave sine table geometry (depth is a power of two).
  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(4 * SINE_DEPTH);
  localparam int SINE_W     = FRAC + 1;

  // Pi in Q30 and the derived constants in QF.
  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint          PI_QF     = longint'((PI_Q30 + (64'd1 << (29 - FRAC))) >>
                                                   (30 - FRAC));
  localparam longint          TWO_PI_QF = longint'((2 * PI_Q30 + (64'd1 << (29 - FRAC))) >>
                                                   (30 - FRAC));
  localparam int              DVS_W     = $clog2(TWO_PI_QF + 1);

  // Shared multiplier geometry: wide signed A, narrow signed B, one B bit a cycle.
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 24;

  // Divider geometry: magnitude bits of the dividend and width of the quotient.
  localparam int DIV_W = 40;
  localparam int QUO_W = 24;

  // Reciprocal of 2*pi in QF, scaled by 2^RECIP_SH. For dividends below 2^40 the
  // estimate it gives is the true quotient or one less.
  localparam int     RECIP_SH = 41;
  localparam longint RECIP_QF = longint'((64'd1 << RECIP_SH) / TWO_PI_QF);

  // Saturation limits.
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam longint VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -VEL_MAX - 1;

  localparam longint unsigned TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20,
                                                 64'd6};

  typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_DEPTH];

  // Multiplier request: start pulse, operands and accumulator start value.
  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
    logic signed [MUL_AW-1:0] init;
  } mul_req_t;

  // Divider request: start pulse, signed dividend and quotient magnitude estimate.
  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] dividend;
    logic        [QUO_W-1:0]  est;
  } div_req_t;

  // Builds the table with an integer Taylor series evaluated in Horner form.
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned one;
    one = 64'd1 << 30;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (PI_Q30 * longint'(k)) / (2 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      t  = one;
      for (int i = 0; i < 6; i++) begin
        t = one - ((x2 * t) >> 30) / TAYLOR_DIV[i];
      end
      s      = (x * t) >> 30;
      tab[k] = SINE_W'((s + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Full-wave sine from the quarter-wave table.
  function automatic logic signed [SINE_W:0] sine_lookup(input logic [SINE_AW-1:0] a);
    logic [1:0]           q;
    logic [SINE_AW-3:0]   r;
    logic [SINE_AW-2:0]   idx;
    logic signed [SINE_W:0] v;
    q   = a[SINE_AW-1 -: 2];
    r   = a[SINE_AW-3:0];
    idx = q[0] ? ((SINE_AW-1)'(SINE_DEPTH) - (SINE_AW-1)'(r)) : (SINE_AW-1)'(r);
    v   = (SINE_W+1)'(SINE_TAB[idx]);
    return q[1] ? -v : v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    if (v > POS_MAX) begin
      return POS_W'(POS_MAX);
    end else if (v < POS_MIN) begin
      return POS_W'(POS_MIN);
    end
    return POS_W'(v);
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [63:0] v);
    if (v > VEL_MAX) begin
      return VEL_W'(VEL_MAX);
    end else if (v < VEL_MIN) begin
      return VEL_W'(VEL_MIN);
    end
    return VEL_W'(v);
  endfunction

endpackage

FILE: rtl/swing_foot_cycloid_trajectory_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   in_tdata (leg step), in_tuser (action)
// out_      master     out_tvalid/out_tready out_tdata (foot command), out_tuser (swinging)
// cfg_      write      cfg_wr_en             cfg_index, cfg_wdata
//
// A swing item makes sixteen passes through the shared serial multiplier (one B bit a
// cycle), two of them the reciprocal products for the divisions by 2*pi, each followed
// by quotient correction in the divider. A stance item raises out_tvalid in the cycle
// after acceptance; restart and out-of-range leg items give none.
// Reset clears the start valid bits and loads the register defaults. in_tready is
// low from acceptance of an in-range leg item until its result is taken on the output.
module swing_foot_cycloid_trajectory_unit #(
  parameter int LEG_COUNT = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, lowest bit up: leg[3], in_contact[1], phase[16], measured_x[20],
  // measured_y[20], measured_z[20], target_x[20], target_y[20], target_z[20], pad[4]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,
  // in_tuser: action[1]
  input  logic [0:0]   in_tuser,
  // out_tdata, lowest bit up: out_leg[3], pos_x[20], pos_y[20], pos_z[20],
  // vel_x[24], vel_y[24], vel_z[24], pad[1]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // out_tuser: swinging[1]
  output logic [0:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int LEG_IW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int PW     = sfct_pkg::POS_W;
  localparam int AW     = sfct_pkg::MUL_AW;
  localparam int BW     = sfct_pkg::MUL_BW;
  localparam int SW     = sfct_pkg::SINE_W + 1;
  localparam int FR     = sfct_pkg::FRAC;

  localparam logic [1:0] REG_STEP_HEIGHT = 2'd0;
  localparam logic [1:0] REG_INV_SWING   = 2'd1;

  localparam logic signed [BW-1:0] ONE_B = BW'(64'sd1 <<< FR);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_OUT} state_t;

  typedef enum logic [3:0] {
    OP_THETA, OP_M1X, OP_RX, OP_M2X, OP_M3X, OP_M1Y, OP_RY, OP_M2Y, OP_M3Y,
    OP_HC, OP_PP, OP_PPT, OP_HS, OP_T1, OP_VZ1, OP_VZ2
  } op_t;

  state_t state_r;
  op_t    op_r;
  logic   launch_r;
  logic   div_start_r;
  logic   out_valid_r;

  logic [15:0]          h_r;
  logic [15:0]          inv_r;
  logic [LEG_COUNT-1:0] start_valid_r;
  logic signed [PW-1:0] start_x_r [LEG_COUNT];
  logic signed [PW-1:0] start_y_r [LEG_COUNT];
  logic signed [PW-1:0] start_z_r [LEG_COUNT];

  // Working registers of the item in flight.
  logic [15:0]          phase_r;
  logic signed [PW-1:0] st_x_r, st_y_r, st_z_r;
  logic signed [PW-1:0] tgt_x_r, tgt_y_r, tgt_z_r;
  logic signed [SW-1:0] s_r, c_r;
  logic signed [PW-1:0] theta_r;
  logic signed [AW-1:0] tmp_r;
  logic signed [AW-1:0] zacc_r;

  // Result registers.
  logic [2:0]                         out_leg_r;
  logic signed [PW-1:0]               pos_x_r, pos_y_r, pos_z_r;
  logic signed [sfct_pkg::VEL_W-1:0]  vel_x_r, vel_y_r, vel_z_r;
  logic                               swing_r;

  // Input fields.
  logic                 in_action;
  logic [2:0]           in_leg;
  logic                 in_contact;
  logic [15:0]          in_phase;
  logic signed [PW-1:0] in_mx, in_my, in_mz, in_tx, in_ty, in_tz;
  logic [LEG_IW-1:0]    leg_idx;
  logic                 leg_ok;
  logic                 take_meas;
  logic [sfct_pkg::SINE_AW-1:0] ang;

  assign in_action  = in_tuser[0];
  assign in_leg     = in_tdata[2:0];
  assign in_contact = in_tdata[3];
  assign in_phase   = in_tdata[19:4];
  assign in_mx      = in_tdata[39:20];
  assign in_my      = in_tdata[59:40];
  assign in_mz      = in_tdata[79:60];
  assign in_tx      = in_tdata[99:80];
  assign in_ty      = in_tdata[119:100];
  assign in_tz      = in_tdata[139:120];
  assign leg_idx    = in_leg[LEG_IW-1:0];
  assign leg_ok     = (4'(in_leg) < 4'(LEG_COUNT));
  assign take_meas  = in_contact | ~start_valid_r[leg_idx];
  assign ang        = in_phase[sfct_pkg::PHASE_W-1 -: sfct_pkg::SINE_AW];

  // Differences to the target, one bit wider than a position.
  logic signed [PW:0] dx, dy;
  assign dx = (PW+1)'(tgt_x_r) - (PW+1)'(st_x_r);
  assign dy = (PW+1)'(tgt_y_r) - (PW+1)'(st_y_r);

  // Magnitude of the chord product for the reciprocal multiplication.
  logic signed [AW-1:0] tmp_abs;
  assign tmp_abs = tmp_r[AW-1] ? -tmp_r : tmp_r;

  // Operand selection for the shared multiplier.
  sfct_pkg::mul_req_t mul_req;
  logic                 mul_done;
  logic signed [AW-1:0] mul_prod;

  always_comb begin
    mul_req.start = launch_r;
    mul_req.init  = '0;
    unique case (op_r)
      OP_THETA: begin
        mul_req.a = AW'(sfct_pkg::TWO_PI_QF);
        mul_req.b = BW'(phase_r);
      end
      OP_M1X: begin
        mul_req.a = AW'(dx);
        mul_req.b = BW'(theta_r) - BW'(s_r);
      end
      OP_M2X: begin
        mul_req.a = AW'(dx);
        mul_req.b = ONE_B - BW'(c_r);
      end
      OP_M1Y: begin
        mul_req.a = AW'(dy);
        mul_req.b = BW'(theta_r) - BW'(s_r);
      end
      OP_M2Y: begin
        mul_req.a = AW'(dy);
        mul_req.b = ONE_B - BW'(c_r);
      end
      OP_RX, OP_RY: begin
        mul_req.a = tmp_abs;
        mul_req.b = BW'(sfct_pkg::RECIP_QF);
      end
      OP_M3X, OP_M3Y, OP_VZ2: begin
        mul_req.a = tmp_r;
        mul_req.b = BW'(inv_r);
      end
      OP_HC: begin
        mul_req.a = AW'(h_r);
        mul_req.b = ONE_B - BW'(c_r);
      end
      OP_PP: begin
        mul_req.a = AW'(phase_r);
        mul_req.b = BW'(phase_r);
      end
      OP_PPT: begin
        mul_req.a = tmp_r;
        mul_req.b = BW'(tgt_z_r);
      end
      OP_HS: begin
        mul_req.a = AW'(s_r);
        mul_req.b = BW'(h_r);
      end
      OP_T1: begin
        mul_req.a = tmp_r;
        mul_req.b = BW'(sfct_pkg::PI_QF);
      end
      OP_VZ1: begin
        mul_req.a    = AW'(tgt_z_r) <<< 1;
        mul_req.b    = BW'(phase_r);
        mul_req.init = tmp_r;
      end
    endcase
  end

  sfct_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  sfct_pkg::div_req_t                div_req;
  logic                              div_done;
  logic signed [sfct_pkg::QUO_W-1:0] div_quo;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = tmp_r;
  assign div_req.est      = sfct_pkg::QUO_W'(mul_prod >>> sfct_pkg::RECIP_SH);

  sfct_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sequencer, configuration, leg store and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_THETA;
      launch_r      <= 1'b0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      start_valid_r <= '0;
      h_r           <= 16'd5243;
      inv_r         <= 16'd512;
    end else begin
      launch_r    <= 1'b0;
      div_start_r <= 1'b0;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_STEP_HEIGHT: h_r   <= cfg_wdata;
          REG_INV_SWING:   inv_r <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (in_action) begin
              start_valid_r <= '0;
            end else if (leg_ok) begin
              if (take_meas) begin
                start_x_r[leg_idx]     <= in_mx;
                start_y_r[leg_idx]     <= in_my;
                start_z_r[leg_idx]     <= in_mz;
                start_valid_r[leg_idx] <= 1'b1;
                st_x_r <= in_mx;
                st_y_r <= in_my;
                st_z_r <= in_mz;
              end else begin
                st_x_r <= start_x_r[leg_idx];
                st_y_r <= start_y_r[leg_idx];
                st_z_r <= start_z_r[leg_idx];
              end
              out_leg_r <= in_leg;
              phase_r   <= in_phase;
              tgt_x_r   <= in_tx;
              tgt_y_r   <= in_ty;
              tgt_z_r   <= in_tz;
              s_r       <= sfct_pkg::sine_lookup(ang);
              c_r       <= sfct_pkg::sine_lookup(ang +
                                                 sfct_pkg::SINE_AW'(sfct_pkg::SINE_DEPTH));
              if (in_contact) begin
                // Stance: hold the measured foot at rest.
                pos_x_r     <= in_mx;
                pos_y_r     <= in_my;
                pos_z_r     <= in_mz;
                vel_x_r     <= '0;
                vel_y_r     <= '0;
                vel_z_r     <= '0;
                swing_r     <= 1'b0;
                out_valid_r <= 1'b1;
                state_r     <= ST_OUT;
              end else begin
                swing_r  <= 1'b1;
                op_r     <= OP_THETA;
                launch_r <= 1'b1;
                state_r  <= ST_RUN;
              end
            end
          end
        end

        ST_RUN: begin
          if (mul_done) begin
            unique case (op_r)
              OP_THETA: theta_r <= PW'(mul_prod >>> FR);
              OP_M1X, OP_M1Y, OP_M2X, OP_M2Y, OP_PP, OP_T1, OP_VZ1: tmp_r <= mul_prod;
              OP_M3X: vel_x_r <= sfct_pkg::sat_vel(mul_prod >>> (FR + 8));
              OP_M3Y: vel_y_r <= sfct_pkg::sat_vel(mul_prod >>> (FR + 8));
              OP_HC:  zacc_r  <= AW'(st_z_r) + (mul_prod >>> (FR + 1));
              OP_PPT: pos_z_r <= sfct_pkg::sat_pos(zacc_r + (mul_prod >>> (2 * FR)));
              OP_HS:  tmp_r   <= mul_prod >>> FR;
              OP_VZ2: vel_z_r <= sfct_pkg::sat_vel(mul_prod >>> (FR + 8));
              default: ;
            endcase
            // The reciprocal estimates go through the quotient correction; the last
            // step ends the item.
            if (op_r == OP_RX || op_r == OP_RY) begin
              div_start_r <= 1'b1;
              state_r     <= ST_DIV;
            end else if (op_r == OP_VZ2) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end else begin
              op_r     <= op_t'(op_r + 4'd1);
              launch_r <= 1'b1;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            if (op_r == OP_RX) begin
              pos_x_r <= sfct_pkg::sat_pos(AW'(st_x_r) + AW'(div_quo));
            end else begin
              pos_y_r <= sfct_pkg::sat_pos(AW'(st_y_r) + AW'(div_quo));
            end
            op_r     <= op_t'(op_r + 4'd1);
            launch_r <= 1'b1;
            state_r  <= ST_RUN;
          end
        end

        ST_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, vel_z_r, vel_y_r, vel_x_r, pos_z_r, pos_y_r, pos_x_r, out_leg_r};
  assign out_tuser  = swing_r;

endmodule

FILE: rtl/sfct_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier: one bit of B per cycle, the sign bit of B subtracts.
module sfct_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sfct_pkg::mul_req_t                req,
  output logic                              done,
  output logic signed [sfct_pkg::MUL_AW-1:0] prod
);

  localparam int CW = $clog2(sfct_pkg::MUL_BW);
  localparam logic [CW-1:0] LAST = CW'(sfct_pkg::MUL_BW - 1);

  logic signed [sfct_pkg::MUL_AW-1:0] acc_r;
  logic signed [sfct_pkg::MUL_AW-1:0] a_r;
  logic        [sfct_pkg::MUL_BW-1:0] b_r;
  logic        [CW-1:0]               cnt_r;
  logic                               busy_r;
  logic                               done_r;

  // Load on start, then add or subtract the shifted A for each set bit of B.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        acc_r  <= req.init;
        a_r    <= req.a;
        b_r    <= req.b;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= (cnt_r == LAST) ? acc_r - a_r : acc_r + a_r;
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: rtl/sfct_div.sv
`timescale 1ns / 1ps

// Division by the constant 2*pi in QF, truncating toward zero. The quotient
// magnitude arrives as a reciprocal estimate that is exact or one too small;
// one multiply-back and a compare decide the last step.
module sfct_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sfct_pkg::div_req_t                req,
  output logic                              done,
  output logic signed [sfct_pkg::QUO_W-1:0] quo
);

  localparam int DW = sfct_pkg::DIV_W;
  localparam int QW = sfct_pkg::QUO_W;
  localparam int RW = sfct_pkg::DVS_W;
  localparam logic [RW-1:0] DVS_N = RW'(sfct_pkg::TWO_PI_QF);
  localparam logic [DW-1:0] DVS   = DW'(DVS_N);

  logic [DW-1:0] mag_r;
  logic [QW-1:0] est_r;
  logic [DW-1:0] rem_r;
  logic          neg_r;
  logic          check_r;
  logic          done_r;
  logic [DW-1:0] back;
  logic [QW-1:0] mag_q;
  logic signed [sfct_pkg::MUL_AW-1:0] abs_in;

  assign abs_in = req.dividend[sfct_pkg::MUL_AW-1] ? -req.dividend : req.dividend;
  assign back   = DW'(est_r) * DVS;
  assign mag_q  = est_r + QW'(rem_r >= DVS);

  // Load the estimate, then form the remainder it leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r  <= 1'b0;
      check_r <= 1'b0;
      if (req.start) begin
        mag_r   <= DW'(abs_in);
        est_r   <= req.est;
        neg_r   <= req.dividend[sfct_pkg::MUL_AW-1];
        check_r <= 1'b1;
      end else if (check_r) begin
        rem_r  <= mag_r - back;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -mag_q : mag_q;

endmodule
